[rtl/ecfb_pkg.sv]
// Shared definitions for the escaped capture frame builder.
// Escape codes, item kinds, frame step indexes and the byte select struct.
// No dependencies.
`default_nettype none

package ecfb_pkg;

    // Escape byte and the codes that follow it
    localparam logic [7:0] ESC_BYTE   = 8'h1b;
    localparam logic [7:0] CODE_LIT   = 8'h00;
    localparam logic [7:0] CODE_START = 8'h01;
    localparam logic [7:0] CODE_SEC_A = 8'h02;
    localparam logic [7:0] CODE_SEC_B = 8'h03;
    localparam logic [7:0] CODE_END   = 8'h04;

    // Item kinds carried in tuser
    typedef enum logic [1:0] {
        KIND_START  = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_SWITCH = 2'd2,
        KIND_END    = 2'd3
    } kind_t;

    // Byte positions within one item's output, before stuffing
    localparam int          STEP_W        = 4;
    localparam logic [3:0] STEP_ESC      = 4'd0;
    localparam logic [3:0] STEP_CODE     = 4'd1;
    localparam logic [3:0] STEP_ELAP_LO  = 4'd2;
    localparam logic [3:0] STEP_ELAP_HI  = 4'd3;
    localparam logic [3:0] STEP_CNT_LO   = 4'd4;
    localparam logic [3:0] STEP_CNT_HI   = 4'd5;
    localparam logic [3:0] STEP_ACK      = 4'd6;
    localparam logic [3:0] STEP_SEC_ESC  = 4'd7;
    localparam logic [3:0] STEP_SEC_CODE = 4'd8;

    // Byte chosen for the current step
    typedef struct packed {
        logic [7:0] value;    // byte before stuffing
        logic       payload;  // byte is subject to stuffing
        logic       at_end;   // last step of this item
    } sel_t;

endpackage

`default_nettype wire

[rtl/ecfb_byte_sel.sv]
// Byte selector: picks the unstuffed byte for one step of the held item.
// Purely combinational; depends on ecfb_pkg.
`default_nettype none

module ecfb_byte_sel (
    input  wire ecfb_pkg::kind_t                kind,
    input  wire logic [ecfb_pkg::STEP_W-1:0]    step,
    input  wire logic [15:0]                    elapsed,
    input  wire logic [15:0]                    count,
    input  wire logic [7:0]                     ack,
    input  wire logic [7:0]                     data,
    output ecfb_pkg::sel_t                      sel
);

    // Step table per item kind
    always_comb
    begin
        sel.value   = ecfb_pkg::ESC_BYTE;
        sel.payload = 1'b0;
        sel.at_end  = 1'b0;
        case (kind)
            ecfb_pkg::KIND_START:
            begin
                case (step)
                    ecfb_pkg::STEP_ESC:      sel.value = ecfb_pkg::ESC_BYTE;
                    ecfb_pkg::STEP_CODE:     sel.value = ecfb_pkg::CODE_START;
                    ecfb_pkg::STEP_ELAP_LO:
                    begin
                        sel.value   = elapsed[7:0];
                        sel.payload = 1'b1;
                    end
                    ecfb_pkg::STEP_ELAP_HI:
                    begin
                        sel.value   = elapsed[15:8];
                        sel.payload = 1'b1;
                    end
                    ecfb_pkg::STEP_CNT_LO:
                    begin
                        sel.value   = count[7:0];
                        sel.payload = 1'b1;
                    end
                    ecfb_pkg::STEP_CNT_HI:
                    begin
                        sel.value   = count[15:8];
                        sel.payload = 1'b1;
                    end
                    ecfb_pkg::STEP_ACK:
                    begin
                        sel.value   = ack;
                        sel.payload = 1'b1;
                    end
                    ecfb_pkg::STEP_SEC_ESC:  sel.value = ecfb_pkg::ESC_BYTE;
                    ecfb_pkg::STEP_SEC_CODE:
                    begin
                        sel.value  = ecfb_pkg::CODE_SEC_A;
                        sel.at_end = 1'b1;
                    end
                    default:
                    begin
                        sel.value  = ecfb_pkg::CODE_SEC_A;
                        sel.at_end = 1'b1;
                    end
                endcase
            end
            ecfb_pkg::KIND_DATA:
            begin
                sel.value   = data;
                sel.payload = 1'b1;
                sel.at_end  = 1'b1;
            end
            ecfb_pkg::KIND_SWITCH:
            begin
                if (step == ecfb_pkg::STEP_ESC)
                begin
                    sel.value = ecfb_pkg::ESC_BYTE;
                end
                else
                begin
                    sel.value  = ecfb_pkg::CODE_SEC_B;
                    sel.at_end = 1'b1;
                end
            end
            ecfb_pkg::KIND_END:
            begin
                if (step == ecfb_pkg::STEP_ESC)
                begin
                    sel.value = ecfb_pkg::ESC_BYTE;
                end
                else
                begin
                    sel.value  = ecfb_pkg::CODE_END;
                    sel.at_end = 1'b1;
                end
            end
            default:
            begin
                sel.value  = ecfb_pkg::CODE_END;
                sel.at_end = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/escaped_capture_frame_builder.sv]
// An accepted item is loaded into the work register; each of its bytes is registered
// in the output register. One output byte per cycle unless m_tready stalls; a start item
// gives 9 to 14 bytes, a data byte 1 or 2, a switch or end 2, set by the work step counter.
// A new item is taken in the cycle its predecessor's last byte moves to the output.
// Reset (rst_n low, asynchronous) empties the work and output registers and clears
// the previous time and frame count to zero.
`default_nettype none

module escaped_capture_frame_builder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] timer_now, [23:16] ack_count, [31:24] data_byte
    input  wire logic [1:0]  s_tuser,   // [1:0] kind
    // Output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic             m_tlast
);

    // Frame state
    logic [15:0] prev_time_reg;
    logic [15:0] frame_count_reg;

    // Work register holding the item being serialised
    logic                           work_valid_reg;
    ecfb_pkg::kind_t                work_kind_reg;
    logic [15:0]                    work_elapsed_reg;
    logic [15:0]                    work_count_reg;
    logic [7:0]                     work_ack_reg;
    logic [7:0]                     work_data_reg;
    logic [ecfb_pkg::STEP_W-1:0]    step_reg;
    logic                           stuff_pending_reg;

    // Output register
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;

    ecfb_pkg::sel_t sel;
    ecfb_pkg::kind_t in_kind;
    logic        emit;
    logic        need_stuff;
    logic        item_end;
    logic [7:0]  emit_byte;
    logic        done;
    logic        accept;

    assign in_kind = ecfb_pkg::kind_t'(s_tuser);

    ecfb_byte_sel u_byte_sel (
        .kind    (work_kind_reg),
        .step    (step_reg),
        .elapsed (work_elapsed_reg),
        .count   (work_count_reg),
        .ack     (work_ack_reg),
        .data    (work_data_reg),
        .sel     (sel)
    );

    // Byte to emit and stuffing decision
    always_comb
    begin
        emit = work_valid_reg && (!out_valid_reg || m_tready);
        if (stuff_pending_reg)
        begin
            emit_byte  = ecfb_pkg::CODE_LIT;
            need_stuff = 1'b0;
            item_end   = sel.at_end;
        end
        else
        begin
            emit_byte  = sel.value;
            need_stuff = sel.payload && (sel.value == ecfb_pkg::ESC_BYTE);
            item_end   = sel.at_end && !need_stuff;
        end
        done     = emit && item_end;
        s_tready = !work_valid_reg || done;
        accept   = s_tvalid && s_tready;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg    <= 1'b0;
            step_reg          <= ecfb_pkg::STEP_ESC;
            stuff_pending_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
            prev_time_reg     <= 16'd0;
            frame_count_reg   <= 16'd0;
        end
        else
        begin
            if (accept)
            begin
                work_valid_reg    <= 1'b1;
                step_reg          <= ecfb_pkg::STEP_ESC;
                stuff_pending_reg <= 1'b0;
                if (in_kind == ecfb_pkg::KIND_START)
                begin
                    prev_time_reg   <= s_tdata[15:0];
                    frame_count_reg <= frame_count_reg + 16'd1;
                end
            end
            else if (emit)
            begin
                if (done)
                begin
                    work_valid_reg <= 1'b0;
                end
                stuff_pending_reg <= need_stuff;
                if (!need_stuff)
                begin
                    step_reg <= step_reg + {{(ecfb_pkg::STEP_W-1){1'b0}}, 1'b1};
                end
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            work_kind_reg    <= in_kind;
            work_elapsed_reg <= prev_time_reg - s_tdata[15:0];
            work_count_reg   <= frame_count_reg;
            work_ack_reg     <= s_tdata[23:16];
            work_data_reg    <= s_tdata[31:24];
        end
        if (emit)
        begin
            out_byte_reg <= emit_byte;
            out_last_reg <= item_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTH
    // A pending stuff byte always follows an escape byte waiting at the output
    a_stuff_follows_esc: assert property (@(posedge clk) disable iff (!rst_n)
        stuff_pending_reg |-> (m_tvalid && m_tdata == ecfb_pkg::ESC_BYTE))
        else $error("stuff pending without escape byte at output");

    // Stuff pending only while an item is held
    a_stuff_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
        stuff_pending_reg |-> work_valid_reg)
        else $error("stuff pending with empty work register");

    // Step counter stays inside the longest item
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        work_valid_reg |-> (step_reg <= ecfb_pkg::STEP_SEC_CODE))
        else $error("step counter out of range");

    // A start transfer advances the frame count by one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_kind == ecfb_pkg::KIND_START)
        |=> (frame_count_reg == $past(frame_count_reg) + 16'd1))
        else $error("frame count did not advance");
`endif

endmodule

`default_nettype wire
